// ===== sv/heater_fault_monitor_defines.svh =====
// Assertion macros shared by the heater fault monitor RTL.
`ifndef HEATER_FAULT_MONITOR_DEFINES_SVH
`define HEATER_FAULT_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define HFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("heater fault monitor assertion failed");
// Clocked check that also holds during reset.
`define HFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("heater fault monitor assertion failed");
`else
`define HFM_ASSERT(lbl, clk, rst_n, prop)
`define HFM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/hfm_pkg.sv =====
// Types and constants of the heater fault monitor.
package hfm_pkg;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_ACTIVE   = 2'd2
  } hfm_status_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } hfm_op_e;

  localparam int unsigned TempW  = 16;
  localparam int unsigned CfgAdW = 3;

  // Fault selection codes of a clear word.
  localparam logic [1:0] SEL_ELEC   = 2'd0;
  localparam logic [1:0] SEL_FLOOR1 = 2'd1;
  localparam logic [1:0] SEL_FLOOR2 = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgAdW-1:0] REG_ELEC_CRIT   = 3'd0;
  localparam logic [CfgAdW-1:0] REG_FLOOR1_CRIT = 3'd1;
  localparam logic [CfgAdW-1:0] REG_FLOOR2_CRIT = 3'd2;
  localparam logic [CfgAdW-1:0] REG_BOILER_THR  = 3'd3;
  localparam logic [CfgAdW-1:0] REG_FLOOR_DELAY = 3'd4;
  localparam logic [CfgAdW-1:0] REG_PELLET      = 3'd5;

  localparam logic signed [TempW-1:0] LowLimit  = -16'sd5;
  localparam logic signed [TempW-1:0] TempMax   = 16'sh7fff;
  localparam logic [TempW-1:0]        CountMax  = 16'hffff;

  // Per-cycle control of one fault channel.
  typedef struct packed {
    logic en;   // a word moves to the result stage
    logic upd;  // the word is a sensor update
    logic clr;  // the word clears this fault
  } hfm_ctrl_t;

endpackage

// ===== sv/hfm_valve_timer.sv =====
// Persistence counter of the floor valve rule for one floor circuit.
module hfm_valve_timer
  import hfm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             pellet_i,
  input  logic             cond_i,
  input  logic [TempW-1:0] delay_i,
  output logic             fire_o
);

  logic [TempW-1:0] cnt_q, cnt_d;

  assign fire_o = pellet_i && cond_i && (cnt_q >= delay_i);

  always_comb begin
    cnt_d = cnt_q;
    if (en_i) begin
      if (!cond_i) begin
        cnt_d = '0;
      end else if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/hfm_fault_chan.sv =====
// Status and peak registers of one fault with its update and clear logic.
module hfm_fault_chan
  import hfm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hfm_ctrl_t               ctrl_i,
  input  logic                    ok_i,
  input  logic signed [TempW-1:0] temp_i,
  input  logic signed [TempW-1:0] crit_i,
  input  logic                    extra_i,
  output hfm_status_e             status_o,
  output logic signed [TempW-1:0] peak_o,
  output logic                    peak_set_o
);

  hfm_status_e             st_q, st_d, st_upd;
  logic signed [TempW-1:0] peak_q, peak_d;
  logic                    rec_q, rec_d;
  logic                    cause;

  assign cause = extra_i || !(ok_i && (temp_i >= LowLimit) && (temp_i <= crit_i));

  always_comb begin
    st_upd = st_q;
    if (cause) begin
      st_upd = ST_ACTIVE;
    end else if (st_q == ST_ACTIVE) begin
      st_upd = ST_PRESENT;
    end

    st_d   = st_q;
    peak_d = peak_q;
    rec_d  = rec_q;
    if (ctrl_i.en && ctrl_i.upd) begin
      st_d = st_upd;
      if (st_upd == ST_ACTIVE && ok_i && (!rec_q || temp_i > peak_q)) begin
        peak_d = temp_i;
        rec_d  = 1'b1;
      end
    end else if (ctrl_i.en && ctrl_i.clr && st_q != ST_INACTIVE) begin
      st_d   = ST_INACTIVE;
      peak_d = '0;
      rec_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_INACTIVE;
      peak_q <= '0;
      rec_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      peak_q <= peak_d;
      rec_q  <= rec_d;
    end
  end

  assign status_o   = st_q;
  assign peak_o     = peak_q;
  assign peak_set_o = rec_q;

endmodule

// ===== sv/heater_fault_monitor.sv =====
// Top level of the heater fault monitor: input stage, configuration and result stage.
// The monitor takes one word per clock cycle while the output is not stalled and returns
// one result word for each. A word first lands in an input register; the compare logic
// then updates the fault status, peak and valve counter registers, which together with
// the output valid flag form the result register. The result word is offered once its
// word has passed from the input register into the result register, and is taken when
// the consumer is ready. The input register keeps accepting while a result waits to be
// taken, so a stalled consumer costs no throughput until both stages are full.
// Configuration writes take effect at the edge they are issued and should only be made
// while no word is in flight.
module heater_fault_monitor
  import hfm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CfgAdW-1:0]        cfg_addr_i,
  input  logic [TempW-1:0]         cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic [1:0]               fault_select_i,
  input  logic signed [TempW-1:0]  elec_temp_i,
  input  logic                     elec_ok_i,
  input  logic signed [TempW-1:0]  floor1_temp_i,
  input  logic                     floor1_ok_i,
  input  logic signed [TempW-1:0]  floor2_temp_i,
  input  logic                     floor2_ok_i,
  input  logic signed [TempW-1:0]  boiler_temp_i,
  input  logic                     boiler_ok_i,
  input  logic                     valve1_open_i,
  input  logic                     valve2_open_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     elec_disable_o,
  output logic                     floor1_disable_o,
  output logic                     floor2_disable_o,
  output logic [1:0]               elec_status_o,
  output logic [1:0]               floor1_status_o,
  output logic [1:0]               floor2_status_o,
  output logic signed [TempW-1:0]  elec_peak_o,
  output logic signed [TempW-1:0]  floor1_peak_o,
  output logic signed [TempW-1:0]  floor2_peak_o,
  output logic                     elec_peak_set_o,
  output logic                     floor1_peak_set_o,
  output logic                     floor2_peak_set_o
);

`include "heater_fault_monitor_defines.svh"

  // Configuration registers.
  logic signed [TempW-1:0] elec_crit_q, floor1_crit_q, floor2_crit_q, boiler_thr_q;
  logic [TempW-1:0]        delay_q;
  logic                    pellet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elec_crit_q   <= TempMax;
      floor1_crit_q <= TempMax;
      floor2_crit_q <= TempMax;
      boiler_thr_q  <= TempMax;
      delay_q       <= '0;
      pellet_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ELEC_CRIT:   elec_crit_q   <= cfg_data_i;
        REG_FLOOR1_CRIT: floor1_crit_q <= cfg_data_i;
        REG_FLOOR2_CRIT: floor2_crit_q <= cfg_data_i;
        REG_BOILER_THR:  boiler_thr_q  <= cfg_data_i;
        REG_FLOOR_DELAY: delay_q       <= cfg_data_i;
        REG_PELLET:      pellet_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input stage. The payload needs no reset; only the valid flag does.
  logic                    s1_valid_q, out_valid_q, advance;
  hfm_op_e                 s1_op_q;
  logic [1:0]              s1_sel_q;
  logic signed [TempW-1:0] s1_et_q, s1_f1t_q, s1_f2t_q, s1_bt_q;
  logic                    s1_eok_q, s1_f1ok_q, s1_f2ok_q, s1_bok_q, s1_v1_q, s1_v2_q;

  // A word moves on when the result register is empty or being emptied.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= hfm_op_e'(opcode_i);
      s1_sel_q  <= fault_select_i;
      s1_et_q   <= elec_temp_i;
      s1_eok_q  <= elec_ok_i;
      s1_f1t_q  <= floor1_temp_i;
      s1_f1ok_q <= floor1_ok_i;
      s1_f2t_q  <= floor2_temp_i;
      s1_f2ok_q <= floor2_ok_i;
      s1_bt_q   <= boiler_temp_i;
      s1_bok_q  <= boiler_ok_i;
      s1_v1_q   <= valve1_open_i;
      s1_v2_q   <= valve2_open_i;
    end
  end

  // Result valid flag: set when a word is applied, dropped when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // Decode of the word in the input stage.
  logic      is_upd, is_clr, hot, fire1, fire2;
  hfm_ctrl_t ctrl_elec, ctrl_f1, ctrl_f2;

  assign is_upd = (s1_op_q == OP_UPDATE);
  assign is_clr = (s1_op_q == OP_CLEAR);

  // The boiler only counts as hot with a valid reading above the threshold.
  assign hot = s1_bok_q && (s1_bt_q > boiler_thr_q);

  assign ctrl_elec = '{en: advance, upd: is_upd, clr: is_clr && (s1_sel_q == SEL_ELEC)};
  assign ctrl_f1   = '{en: advance, upd: is_upd, clr: is_clr && (s1_sel_q == SEL_FLOOR1)};
  assign ctrl_f2   = '{en: advance, upd: is_upd, clr: is_clr && (s1_sel_q == SEL_FLOOR2)};

  // The valve counters move only on updates in pellet mode.
  hfm_valve_timer u_timer1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance && is_upd && pellet_q),
    .pellet_i (pellet_q),
    .cond_i   (s1_v1_q && hot),
    .delay_i  (delay_q),
    .fire_o   (fire1)
  );

  hfm_valve_timer u_timer2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance && is_upd && pellet_q),
    .pellet_i (pellet_q),
    .cond_i   (s1_v2_q && hot),
    .delay_i  (delay_q),
    .fire_o   (fire2)
  );

  hfm_status_e st_elec, st_f1, st_f2;

  // Electric heater fault has no extra cause.
  hfm_fault_chan u_elec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_elec),
    .ok_i       (s1_eok_q),
    .temp_i     (s1_et_q),
    .crit_i     (elec_crit_q),
    .extra_i    (1'b0),
    .status_o   (st_elec),
    .peak_o     (elec_peak_o),
    .peak_set_o (elec_peak_set_o)
  );

  hfm_fault_chan u_floor1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_f1),
    .ok_i       (s1_f1ok_q),
    .temp_i     (s1_f1t_q),
    .crit_i     (floor1_crit_q),
    .extra_i    (fire1),
    .status_o   (st_f1),
    .peak_o     (floor1_peak_o),
    .peak_set_o (floor1_peak_set_o)
  );

  hfm_fault_chan u_floor2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl_f2),
    .ok_i       (s1_f2ok_q),
    .temp_i     (s1_f2t_q),
    .crit_i     (floor2_crit_q),
    .extra_i    (fire2),
    .status_o   (st_f2),
    .peak_o     (floor2_peak_o),
    .peak_set_o (floor2_peak_set_o)
  );

  // The fault registers change only when the result register reloads, so they
  // drive the result fields directly.
  assign elec_status_o    = st_elec;
  assign floor1_status_o  = st_f1;
  assign floor2_status_o  = st_f2;
  assign elec_disable_o   = (st_elec != ST_INACTIVE);
  assign floor1_disable_o = (st_f1 != ST_INACTIVE);
  assign floor2_disable_o = (st_f2 != ST_INACTIVE);

  // An unrecorded peak always reads as zero.
  `HFM_ASSERT_ALWAYS(a_peak_zero, clk_i, !elec_peak_set_o |-> elec_peak_o == '0)
  // An inactive fault never holds a recorded peak.
  `HFM_ASSERT_ALWAYS(a_f1_inactive_nopeak, clk_i, st_f1 == ST_INACTIVE |-> !floor1_peak_set_o)
  `HFM_ASSERT_ALWAYS(a_f2_inactive_nopeak, clk_i, st_f2 == ST_INACTIVE |-> !floor2_peak_set_o)
  // Input is held off only when both stages are full and the output stalls.
  `HFM_ASSERT(a_stall_cause, clk_i, rst_ni,
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
  // A new result appears only from a word in the input stage.
  `HFM_ASSERT(a_result_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(s1_valid_q))

endmodule
